@@ rtl/wfa_pkg.sv @@
`default_nettype none

package wfa_pkg;

	// window shapes selected by the window_kind register
	typedef enum logic [1:0] {
		KIND_HANN     = 2'd0,
		KIND_HAMMING  = 2'd1,
		KIND_BLACKMAN = 2'd2,
		KIND_BARTLETT = 2'd3
	} wfa_kind_t;

	// configuration register indexes
	localparam logic [1:0] REG_KIND   = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;
	localparam logic [1:0] REG_STEP   = 2'd2;

	// register reset values
	localparam logic [15:0] LENGTH_RESET = 16'd1024;
	localparam logic [31:0] STEP_RESET   = 32'd4194304;

	// sequencer states; an item walks from ST_COS through ST_FIN
	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_COS  = 3'd1,
		ST_MIX  = 3'd2,
		ST_WIN  = 3'd3,
		ST_FIN  = 3'd4
	} wfa_state_t;

	// step strobes from the sequencer to the coefficient unit
	typedef struct packed {
		logic load;
		logic cos_step;
		logic mix_step;
		logic win_step;
	} wfa_ctrl_t;

	// cosine table format: Q30, clamped to [0, 1]
	localparam int COS_W = 31;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// window constants in Q30
	localparam logic [29:0] K054 = 30'd579820585;
	localparam logic [29:0] K046 = 30'd493921239;
	localparam logic [29:0] K042 = 30'd450971566;
	localparam logic [29:0] K050 = 30'd536870912;
	localparam logic [29:0] K008 = 30'd85899346;

	// one in Q60, the upper clamp of the window value
	localparam logic signed [62:0] ONE_Q60 = 63'sh1000_0000_0000_0000;

endpackage

`default_nettype wire

@@ rtl/wfa_cos_rom.sv @@
`default_nettype none

module wfa_cos_rom
	import wfa_pkg::*;
#(
	parameter int COS_TABLE_BITS = 10
) (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [COS_TABLE_BITS:0]   rd_addr,
	output logic      [COS_W-1:0]          rd_data
);

	localparam int TAB_SIZE = 1 << COS_TABLE_BITS;

	typedef logic [COS_W-1:0] cos_rom_t [TAB_SIZE+1];

	// floor quotient by shift and subtract, only used while the table is built
	function automatic longint unsigned div_floor(longint unsigned num,
		longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// quarter-wave cosine, truncating Taylor series of ten terms
	function automatic cos_rom_t build_rom();
		cos_rom_t       r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned mag;
		longint          sum;
		for (int k = 0; k <= TAB_SIZE; k++) begin
			x   = (longint'(k) * HALF_PI_Q30) >> COS_TABLE_BITS;
			x2  = (x * x) >> 30;
			mag = ONE_Q30;
			sum = ONE_Q30;
			for (int n = 1; n <= 9; n++) begin
				mag = div_floor((mag * x2) >> 30, $unsigned(64'((2 * n - 1) * (2 * n))));
				if (n % 2 == 1) begin
					sum = sum - longint'(mag);
				end else begin
					sum = sum + longint'(mag);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > ONE_Q30) begin
				sum = ONE_Q30;
			end
			r[k] = sum[COS_W-1:0];
		end
		return r;
	endfunction

	localparam cos_rom_t COS_ROM = build_rom();

	logic [COS_W-1:0] rd_data_q;

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= COS_ROM[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/wfa_coef_unit.sv @@
`default_nettype none

module wfa_coef_unit
	import wfa_pkg::*;
#(
	parameter int COEF_FRAC_BITS = 16,
	parameter int COS_TABLE_BITS = 10
) (
	input  wire logic                    clk,
	input  wire wfa_ctrl_t               ctrl,
	input  wire wfa_kind_t               kind,
	input  wire logic [31:0]             phase,
	output logic      [COEF_FRAC_BITS:0] coef
);

	localparam int TB = COS_TABLE_BITS;
	localparam int SH = 60 - COEF_FRAC_BITS;
	localparam logic [TB:0] TAB_SIZE = {1'b1, {TB{1'b0}}};

	logic [31:0]               phase_q;
	logic                      neg_q;
	logic [31:0]               addr_phase;
	logic [TB-1:0]             tab_idx;
	logic [TB:0]               rom_addr;
	logic                      rom_en;
	logic [COS_W-1:0]          rom_data;
	logic signed [31:0]        cos_val;
	logic [29:0]               k_a;
	logic [29:0]               k_c;
	logic [29:0]               mul_k;
	logic signed [62:0]        mul_p;
	logic signed [62:0]        prod_q;
	logic signed [62:0]        acc_q;
	logic signed [62:0]        a_ext;
	logic [31:0]               tri_p;
	logic signed [62:0]        w_val;
	logic [60:0]               w_clamp;
	logic [60:0]               w_round;
	logic [COEF_FRAC_BITS:0]   coef_raw;
	logic [COEF_FRAC_BITS:0]   coef_q;

	// phase for the table read: item phase at load, doubled phase after
	assign addr_phase = ctrl.load ? phase : {phase_q[30:0], 1'b0};
	assign tab_idx    = addr_phase[29:30-TB];
	assign rom_addr   = addr_phase[30] ? (TAB_SIZE - {1'b0, tab_idx}) : {1'b0, tab_idx};
	assign rom_en     = ctrl.load | ctrl.cos_step;

	wfa_cos_rom #(
		.COS_TABLE_BITS(COS_TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.rd_en  (rom_en),
		.rd_addr(rom_addr),
		.rd_data(rom_data)
	);

	// quadrant sign and phase capture
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			phase_q <= phase;
		end
		if (rom_en) begin
			neg_q <= addr_phase[31] ^ addr_phase[30];
		end
	end

	// signed cosine from the quarter-wave entry
	assign cos_val = neg_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

	// window constants: offset and cosine weight
	always_comb begin
		case (kind)
			KIND_HANN: begin
				k_a = K050;
				k_c = K050;
			end
			KIND_HAMMING: begin
				k_a = K054;
				k_c = K046;
			end
			KIND_BLACKMAN: begin
				k_a = K042;
				k_c = K050;
			end
			default: begin
				k_a = '0;
				k_c = '0;
			end
		endcase
	end

	// shared multiplier: cosine weight first, then the second harmonic
	assign mul_k = ctrl.cos_step ? k_c : K008;
	assign mul_p = $signed({1'b0, mul_k}) * cos_val;
	assign a_ext = $signed({3'b000, k_a, 30'd0});

	always_ff @(posedge clk) begin
		if (ctrl.cos_step) begin
			prod_q <= mul_p;
		end else if (ctrl.mix_step) begin
			acc_q  <= a_ext - prod_q;
			prod_q <= (kind == KIND_BLACKMAN) ? mul_p : '0;
		end
	end

	// triangle from the phase, cosine sum otherwise
	assign tri_p = phase_q[31] ? (~phase_q + 32'd1) : phase_q;

	always_comb begin
		if (kind == KIND_BARTLETT) begin
			w_val = $signed({2'b00, tri_p, 29'd0});
		end else begin
			w_val = acc_q + prod_q;
		end
	end

	// clamp to [0, 1] in Q60, round half up to the coefficient width
	always_comb begin
		if (w_val[62]) begin
			w_clamp = '0;
		end else if (w_val > ONE_Q60) begin
			w_clamp = ONE_Q60[60:0];
		end else begin
			w_clamp = w_val[60:0];
		end
	end

	assign w_round  = w_clamp + (61'd1 << (SH - 1));
	assign coef_raw = w_round[60:SH];

	always_ff @(posedge clk) begin
		if (ctrl.win_step) begin
			if (coef_raw[COEF_FRAC_BITS] && (|coef_raw[COEF_FRAC_BITS-1:0])) begin
				coef_q <= {1'b1, {COEF_FRAC_BITS{1'b0}}};
			end else begin
				coef_q <= coef_raw;
			end
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

@@ rtl/window_function_apply.sv @@
// Window function unit. Each sample word is multiplied by the coefficient of the
// selected window (Hann, Hamming, Blackman or Bartlett) at the current frame
// position, given by a 32-bit phase accumulator that advances by phase_step and
// restarts with the frame index at window_length. An accepted sample steps through
// the cosine, mix, window and final states before its result register is loaded;
// the next sample is taken in the cycle the result is loaded, not before. The
// steps are set by the two reads of the single-port quarter-wave cosine ROM and
// the one shared multiplier that weights both cosine terms. A finished result
// waits in the output register while the next sample is already being worked on.
// Configuration writes are to be made only while no sample is in flight.
`default_nettype none

module window_function_apply
	import wfa_pkg::*;
#(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 16,
	parameter int COS_TABLE_BITS = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [31:0]                       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]          windowed_sample,
	output logic        [COEF_FRAC_BITS:0]         coefficient,
	output logic                                   last_of_frame
);

	localparam int PW = SAMPLE_BITS + COEF_FRAC_BITS + 2;
	localparam int YW = PW - COEF_FRAC_BITS;
	localparam logic signed [PW-1:0] RND_HALF =
		$signed({{(PW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}});
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	wfa_kind_t                       window_kind_q;
	logic [15:0]                     window_length_q;
	logic [31:0]                     phase_step_q;
	logic [31:0]                     phase_accum_q;
	logic [15:0]                     frame_index_q;
	wfa_state_t                      state_q;
	wfa_state_t                      state_d;
	wfa_ctrl_t                       ctrl;
	logic                            in_acc;
	logic                            out_free;
	logic                            out_load;
	logic                            last_c;
	logic signed [SAMPLE_BITS-1:0]   sample_q;
	logic                            last_q;
	logic [COEF_FRAC_BITS:0]         coef;
	logic signed [PW-1:0]            prod;
	logic signed [PW-1:0]            prod_rnd;
	logic signed [YW-1:0]            y_full;
	logic signed [SAMPLE_BITS-1:0]   y_sat;
	logic                            out_valid_q;
	logic signed [SAMPLE_BITS-1:0]   wsample_q;
	logic [COEF_FRAC_BITS:0]         coef_out_q;
	logic                            last_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_kind_q   <= KIND_HANN;
			window_length_q <= LENGTH_RESET;
			phase_step_q    <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KIND:   window_kind_q   <= wfa_kind_t'(cfg_data[1:0]);
				REG_LENGTH: window_length_q <= cfg_data[15:0];
				REG_STEP:   phase_step_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// handshake terms
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_FIN) && out_free;
	assign last_c   = ({1'b0, frame_index_q} + 17'd1) >= {1'b0, window_length_q};

	// frame position, advanced as each word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_accum_q <= '0;
			frame_index_q <= '0;
		end else if (in_acc) begin
			if (last_c) begin
				phase_accum_q <= '0;
				frame_index_q <= '0;
			end else begin
				phase_accum_q <= phase_accum_q + phase_step_q;
				frame_index_q <= frame_index_q + 16'd1;
			end
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
			last_q   <= last_c;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_COS;
				end
			end
			ST_COS: state_d = ST_MIX;
			ST_MIX: state_d = ST_WIN;
			ST_WIN: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = in_valid ? ST_COS : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall      = 1'b1;
		ctrl.cos_step = 1'b0;
		ctrl.mix_step = 1'b0;
		ctrl.win_step = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_COS:  ctrl.cos_step = 1'b1;
			ST_MIX:  ctrl.mix_step = 1'b1;
			ST_WIN:  ctrl.win_step = 1'b1;
			ST_FIN:  in_stall = !out_free;
			default: in_stall = 1'b1;
		endcase
		ctrl.load = in_valid && !in_stall;
	end

	wfa_coef_unit #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.COS_TABLE_BITS(COS_TABLE_BITS)
	) u_coef (
		.clk  (clk),
		.ctrl (ctrl),
		.kind (window_kind_q),
		.phase(phase_accum_q),
		.coef (coef)
	);

	// sample times coefficient, round half up, saturate
	assign prod     = sample_q * $signed({1'b0, coef});
	assign prod_rnd = prod + RND_HALF;
	assign y_full   = YW'(prod_rnd >>> COEF_FRAC_BITS);

	always_comb begin
		if ((&y_full[YW-1:SAMPLE_BITS-1]) || !(|y_full[YW-1:SAMPLE_BITS-1])) begin
			y_sat = y_full[SAMPLE_BITS-1:0];
		end else if (y_full[YW-1]) begin
			y_sat = SAT_MIN;
		end else begin
			y_sat = SAT_MAX;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			wsample_q  <= y_sat;
			coef_out_q <= coef;
			last_out_q <= last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign windowed_sample = wsample_q;
	assign coefficient     = coef_out_q;
	assign last_of_frame   = last_out_q;

`ifndef SYNTHESIS
	// an accepted word always starts the cosine read sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_COS)
		else $error("accepted word did not start the sequence");

	// a new result appears only from the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result valid without a finished word");

	// a frame end restarts the position
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_c |=> phase_accum_q == '0 && frame_index_q == '0)
		else $error("frame end did not restart phase and index");

	// the coefficient never exceeds one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(coef_out_q[COEF_FRAC_BITS] && (|coef_out_q[COEF_FRAC_BITS-1:0])))
		else $error("coefficient above one");
`endif

endmodule

`default_nettype wire
